[hdl/smst_pkg.sv]
package smst_pkg;

	localparam int unsigned DefStackDepth = 64;
	localparam int unsigned DataW = 32;

	// Operation codes carried by req_type.
	localparam logic [4:0] OP_PUSH = 5'd0;
	localparam logic [4:0] OP_ADD  = 5'd1;
	localparam logic [4:0] OP_SUB  = 5'd2;
	localparam logic [4:0] OP_MUL  = 5'd3;
	localparam logic [4:0] OP_DIV  = 5'd4;
	localparam logic [4:0] OP_MOD  = 5'd5;
	localparam logic [4:0] OP_LT   = 5'd6;
	localparam logic [4:0] OP_LE   = 5'd7;
	localparam logic [4:0] OP_GT   = 5'd8;
	localparam logic [4:0] OP_GE   = 5'd9;
	localparam logic [4:0] OP_EQ   = 5'd10;
	localparam logic [4:0] OP_NE   = 5'd11;
	localparam logic [4:0] OP_NEG  = 5'd12;
	localparam logic [4:0] OP_AND  = 5'd13;
	localparam logic [4:0] OP_OR   = 5'd14;
	localparam logic [4:0] OP_NOT  = 5'd15;
	localparam logic [4:0] OP_DUP  = 5'd16;
	localparam logic [4:0] OP_DROP = 5'd17;
	localparam logic [4:0] OP_SWAP = 5'd18;
	localparam logic [4:0] OP_ROT  = 5'd19;
	localparam logic [4:0] OP_DOT  = 5'd20;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;
	localparam logic [1:0] ST_DIV0  = 2'd3;

	typedef struct packed {
		logic [4:0]        req_type;
		logic signed [31:0] literal_value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] top_value;
		logic [6:0]         stack_depth;
		logic signed [31:0] printed_value;
		logic               print_valid;
	} rsp_t;

	// Shift direction of the cell row.
	typedef enum logic [1:0] {SH_HOLD, SH_PUSH, SH_POP} shift_t;

	typedef struct packed {
		shift_t shift;
		logic   ld;
	} cell_ctrl_t;

endpackage

[hdl/smst_stream_if.sv]
interface smst_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/stack_machine_execute_unit.sv]
// Channel  Dir  Payload                                                   Word moves when
// req      in   req_type, literal_value                                   valid && ready
// rsp      out  status, top_value, stack_depth, printed_value, print_valid valid && ready
//
// Most operations execute on the cell row in S_EXEC, then load the result
// register in S_FIN, during which the next word can be taken.
// Divide and remainder wait in S_DIV for the bit-serial divider before S_FIN.
// Reset clears the depth count and the control state; stack cells are not reset.
// A result waiting on rsp holds the block before its next result is loaded.
module stack_machine_execute_unit import smst_pkg::*; #(
	parameter int unsigned STACK_DEPTH = DefStackDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	smst_stream_if.sink   req,
	smst_stream_if.source rsp
);
	localparam int unsigned SpW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_FIN} state_t;

	state_t             state_q;
	logic [4:0]         op_q;
	logic [DataW-1:0]   lit_q;
	logic [SpW-1:0]     sp_q;
	logic [SpW-1:0]     sp_d;
	logic [1:0]         status_q;
	logic [1:0]         status_d;
	logic [DataW-1:0]   printed_q;
	logic               pvalid_q;
	logic               pvalid_d;
	logic               out_valid_q;
	rsp_t               out_q;
	logic               out_free;
	logic               in_take;
	logic               go_div;
	logic               div_done;
	logic [DataW-1:0]   div_quot;
	logic [DataW-1:0]   div_rem;
	logic [1:0]         need;
	shift_t             shift;
	logic [2:0]         ld_en;
	logic [DataW-1:0]   ld_val [3];
	logic [DataW-1:0]   cell_q [STACK_DEPTH];
	logic signed [DataW-1:0] a;
	logic signed [DataW-1:0] b;
	logic [DataW-1:0]   c;
	logic [DataW-1:0]   r;
	logic [DataW-1:0]   mag_a;
	logic [DataW-1:0]   mag_b;
	logic [DataW-1:0]   div_res;
	logic [SpW+6:0]     sp_ext;

	assign b = cell_q[0];
	assign a = cell_q[1];
	assign c = cell_q[2];
	assign mag_a = a[DataW-1] ? (DataW'(0) - a) : a;
	assign mag_b = b[DataW-1] ? (DataW'(0) - b) : b;

	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) || (state_q == S_FIN && out_free);
	assign in_take = req.valid && req.ready;

	// Combinational results of the binary operations.
	always_comb begin
		case (op_q)
			OP_ADD:  r = a + b;
			OP_SUB:  r = a - b;
			OP_MUL:  r = a * b;
			OP_LT:   r = DataW'(a < b);
			OP_LE:   r = DataW'(a <= b);
			OP_GT:   r = DataW'(a > b);
			OP_GE:   r = DataW'(a >= b);
			OP_EQ:   r = DataW'(a == b);
			OP_NE:   r = DataW'(a != b);
			OP_AND:  r = DataW'(a == 1 && b == 1);
			default: r = DataW'(a == 1 || b == 1);
		endcase
	end

	// Sign correction of the divider result.
	always_comb begin
		if (op_q == OP_DIV) begin
			div_res = (a[DataW-1] ^ b[DataW-1]) ? (DataW'(0) - div_quot) : div_quot;
		end else begin
			div_res = a[DataW-1] ? (DataW'(0) - div_rem) : div_rem;
		end
	end

	// Operand count of each operation.
	always_comb begin
		case (op_q) inside
			[OP_ADD:OP_NE], OP_AND, OP_OR, OP_SWAP: need = 2'd2;
			OP_NEG, OP_NOT, OP_DUP, OP_DROP, OP_DOT: need = 2'd1;
			OP_ROT:  need = 2'd3;
			default: need = 2'd0;
		endcase
	end

	// Decode into cell-row commands.
	always_comb begin
		shift    = SH_HOLD;
		ld_en    = '0;
		ld_val[0] = r;
		ld_val[1] = b;
		ld_val[2] = a;
		sp_d     = sp_q;
		status_d = ST_OK;
		pvalid_d = 1'b0;
		go_div   = 1'b0;
		if (state_q == S_EXEC) begin
			if (sp_q < SpW'(need)) begin
				status_d = ST_UNDER;
			end else if ((op_q == OP_PUSH || op_q == OP_DUP) &&
					sp_q == SpW'(STACK_DEPTH)) begin
				status_d = ST_OVER;
			end else begin
				case (op_q) inside
					OP_PUSH: begin
						shift = SH_PUSH;
						ld_en[0] = 1'b1;
						ld_val[0] = lit_q;
						sp_d = sp_q + 1'b1;
					end
					OP_DUP: begin
						shift = SH_PUSH;
						ld_en[0] = 1'b1;
						ld_val[0] = b;
						sp_d = sp_q + 1'b1;
					end
					OP_DIV, OP_MOD: begin
						if (b == 0) begin
							status_d = ST_DIV0;
						end else begin
							go_div = 1'b1;
						end
					end
					[OP_ADD:OP_NE], OP_AND, OP_OR: begin
						shift = SH_POP;
						ld_en[0] = 1'b1;
						sp_d = sp_q - 1'b1;
					end
					OP_SWAP: begin
						ld_en[1:0] = 2'b11;
						ld_val[0] = a;
					end
					OP_ROT: begin
						ld_en = 3'b111;
						ld_val[0] = c;
						ld_val[1] = b;
					end
					OP_NEG: begin
						ld_en[0] = 1'b1;
						ld_val[0] = DataW'(0) - b;
					end
					OP_NOT: begin
						ld_en[0] = 1'b1;
						ld_val[0] = DataW'(b == 0);
					end
					OP_DROP: begin
						shift = SH_POP;
						sp_d = sp_q - 1'b1;
					end
					OP_DOT: begin
						shift = SH_POP;
						pvalid_d = 1'b1;
						sp_d = sp_q - 1'b1;
					end
					default: ;
				endcase
			end
		end else if (state_q == S_DIV && div_done) begin
			shift = SH_POP;
			ld_en[0] = 1'b1;
			ld_val[0] = div_res;
			sp_d = sp_q - 1'b1;
		end
	end

	// The row of stack cells; cell 0 is the top.
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		cell_ctrl_t       cc;
		logic [DataW-1:0] up;
		logic [DataW-1:0] dn;
		logic [DataW-1:0] lv;

		assign up = (i == 0) ? cell_q[0] : cell_q[(i == 0) ? 0 : i - 1];
		assign dn = (i == STACK_DEPTH - 1) ? cell_q[i]
			: cell_q[(i == STACK_DEPTH - 1) ? i : i + 1];
		assign cc.shift = shift;
		if (i < 3) begin : g_ld
			assign cc.ld = ld_en[i];
			assign lv    = ld_val[i];
		end else begin : g_nold
			assign cc.ld = 1'b0;
			assign lv    = '0;
		end

		smst_cell u_cell (
			.clk    (clk),
			.ctrl   (cc),
			.up_d   (up),
			.down_d (dn),
			.ld_d   (lv),
			.q      (cell_q[i])
		);
	end

	smst_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (go_div),
		.dividend (mag_a),
		.divisor  (mag_b),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign sp_ext = {7'd0, sp_q};

	// Sequencer, depth count and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			sp_q <= sp_d;
			// A new result sets valid; a taken result clears it.
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= go_div ? S_DIV : S_FIN;
				end
				S_DIV: begin
					if (div_done) state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= in_take ? S_EXEC : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item and result payload registers.
	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q  <= req.data.req_type;
			lit_q <= req.data.literal_value;
		end
		if (state_q == S_EXEC || state_q == S_DIV) begin
			status_q  <= status_d;
			pvalid_q  <= pvalid_d;
			printed_q <= pvalid_d ? b : '0;
		end
		if (state_q == S_FIN && out_free) begin
			out_q.status        <= status_q;
			out_q.top_value     <= (sp_q != 0) ? cell_q[0] : '0;
			out_q.stack_depth   <= sp_ext[6:0];
			out_q.printed_value <= printed_q;
			out_q.print_valid   <= pvalid_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;
endmodule

[hdl/smst_cell.sv]
module smst_cell import smst_pkg::*; (
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic [DataW-1:0] up_d,
	input  logic [DataW-1:0] down_d,
	input  logic [DataW-1:0] ld_d,
	output logic [DataW-1:0] q
);
	logic [DataW-1:0] val_q;

	// A load wins over the shift; otherwise a push or pop takes the neighbor's word.
	always_ff @(posedge clk) begin
		if (ctrl.ld) begin
			val_q <= ld_d;
		end else begin
			case (ctrl.shift)
				SH_PUSH: val_q <= up_d;
				SH_POP:  val_q <= down_d;
				default: val_q <= val_q;
			endcase
		end
	end

	assign q = val_q;
endmodule

[hdl/smst_div.sv]
module smst_div import smst_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DataW-1:0] dividend,
	input  logic [DataW-1:0] divisor,
	output logic             done,
	output logic [DataW-1:0] quot,
	output logic [DataW-1:0] rem
);
	localparam int unsigned CntW = $clog2(DataW + 1);

	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DataW-1:0] rem_q;
	logic [DataW-1:0] quo_q;
	logic [DataW-1:0] dvs_q;
	logic [DataW:0]   trial;

	assign trial = {rem_q, quo_q[DataW-1]} - {1'b0, dvs_q};

	// Control: one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CntW'(DataW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring division datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DataW]) begin
				rem_q <= trial[DataW-1:0];
				quo_q <= {quo_q[DataW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DataW-2:0], quo_q[DataW-1]};
				quo_q <= {quo_q[DataW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;
endmodule
